// ===== src/tkmt_pkg.sv =====
// tkmt_pkg: shared types and constants for the top-k max tracker
// no dependencies; used by the interfaces, the cell and the top level
`default_nettype none

package tkmt_pkg;

    localparam int OP_W    = 2;
    localparam int TAG_W   = 16;
    localparam int KEY_W   = 16;
    localparam int RANK_W  = 3;
    localparam int COUNT_W = 3;

    // operation codes, code 3 is unused
    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_CLEAR  = 2'd1,
        OP_READ   = 2'd2
    } t_op;

    // what one cell hands to its right-hand neighbor
    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic [KEY_W-1:0] key;
        logic             above;   // valid and key >= incoming key
        logic             at_min;  // key equals the current minimum
    } t_cell_link;

    // broadcast control for every cell
    typedef struct packed {
        logic             wr_en;
        logic             full;
        logic [KEY_W-1:0] min_key;
        logic [TAG_W-1:0] new_tag;
        logic [KEY_W-1:0] new_key;
    } t_cell_ctl;

endpackage

`default_nettype wire

// ===== src/tkmt_if.sv =====
// tkmt_in_if / tkmt_out_if: valid-ready channels of the top-k max tracker
// depends on tkmt_pkg
`default_nettype none

interface tkmt_in_if
    import tkmt_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   operation;
    logic [TAG_W-1:0]  item_tag;
    logic [KEY_W-1:0]  item_key;
    logic [RANK_W-1:0] read_rank;

    modport source (output valid, operation, item_tag, item_key, read_rank, input ready);
    modport sink   (input valid, operation, item_tag, item_key, read_rank, output ready);
endinterface

interface tkmt_out_if
    import tkmt_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [COUNT_W-1:0] entry_count;
    logic               accepted;
    logic [RANK_W-1:0]  placed_rank;
    logic               read_valid;
    logic [TAG_W-1:0]   read_tag;
    logic [KEY_W-1:0]   read_key;

    modport source (output valid, entry_count, accepted, placed_rank, read_valid, read_tag,
                    read_key, input ready);
    modport sink   (input valid, entry_count, accepted, placed_rank, read_valid, read_tag,
                    read_key, output ready);
endinterface

`default_nettype wire

// ===== src/tkmt_cell.sv =====
// tkmt_cell: one rank of the sorted table, holds a tag and a key
// depends on tkmt_pkg; chained left to right by the top level
`default_nettype none

module tkmt_cell
    import tkmt_pkg::*;
(
    input  wire logic       i_clk,
    input  wire t_cell_ctl  i_ctl,
    input  wire logic       i_valid,
    input  wire t_cell_link i_left,
    output t_cell_link      o_link
);

    logic [TAG_W-1:0] r_tag;
    logic [KEY_W-1:0] r_key;
    logic [TAG_W-1:0] n_tag;
    logic [KEY_W-1:0] n_key;
    logic             w_above;

    assign w_above = i_valid && (r_key >= i_ctl.new_key);

    always_comb begin
        n_tag = r_tag;
        n_key = r_key;
        if (i_ctl.wr_en && !w_above) begin
            if (i_left.above) begin
                // first rank below every entry that ranks at least as high
                n_tag = i_ctl.new_tag;
                n_key = i_ctl.new_key;
            end else if (!(i_ctl.full && i_left.at_min)) begin
                // shift down; when full, ranks past the displaced min entry stay
                n_tag = i_left.tag;
                n_key = i_left.key;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_tag <= n_tag;
        r_key <= n_key;
    end

    assign o_link.tag    = r_tag;
    assign o_link.key    = r_key;
    assign o_link.above  = w_above;
    assign o_link.at_min = (r_key == i_ctl.min_key);

endmodule

`default_nettype wire

// ===== src/top_k_max_tracker_unit.sv =====
// top_k_max_tracker_unit: keeps the TABLE_DEPTH largest-key items in rank order
// depends on tkmt_pkg, tkmt_if and tkmt_cell
`default_nettype none

// Top-k tracker built as a row of TABLE_DEPTH cells, rank 0 holding the largest
// key. Insert, clear and read are all decided from the cells' parallel key
// compares and the entry count, and the cells update at the accept edge, so a
// new word can be taken every cycle while the result side drains. The result
// word sits in an output register; the input is ready whenever that register
// is empty or being drained. Ties keep arrival order; when full, a larger key
// displaces the first entry at the minimum key. TABLE_DEPTH ranges from 1 to 7.
module top_k_max_tracker_unit
    import tkmt_pkg::*;
#(
    parameter int TABLE_DEPTH = 5
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    tkmt_in_if.sink     i_in,
    tkmt_out_if.source  o_out
);

    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int RW = (CW > RANK_W) ? CW : RANK_W;

    localparam t_cell_link HEAD_LINK = '{tag: '0, key: '0, above: 1'b1, at_min: 1'b0};

    logic [CW-1:0]      r_count;
    logic [CW-1:0]      n_count;
    logic               r_out_valid;
    logic [COUNT_W-1:0] r_entry_count;
    logic               r_accepted;
    logic [RANK_W-1:0]  r_placed_rank;
    logic               r_read_valid;
    logic [TAG_W-1:0]   r_read_tag;
    logic [KEY_W-1:0]   r_read_key;
    logic               n_accepted;
    logic [RANK_W-1:0]  n_placed_rank;
    logic               n_read_valid;
    logic [TAG_W-1:0]   n_read_tag;
    logic [KEY_W-1:0]   n_read_key;

    logic       w_accept;
    logic       w_full;
    logic       w_ins_ok;
    logic [CW-1:0] w_placed;
    logic       w_rank_ok;
    logic [IW-1:0] w_rd_idx;
    t_cell_ctl  w_ctl;
    t_cell_link w_links [TABLE_DEPTH];

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_full     = (r_count == CW'(TABLE_DEPTH));
    assign w_ins_ok   = !w_full || (i_in.item_key > w_links[TABLE_DEPTH-1].key);

    assign w_ctl.wr_en   = w_accept && (i_in.operation == OP_INSERT) && w_ins_ok;
    assign w_ctl.full    = w_full;
    assign w_ctl.min_key = w_links[TABLE_DEPTH-1].key;
    assign w_ctl.new_tag = i_in.item_tag;
    assign w_ctl.new_key = i_in.item_key;

    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        tkmt_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_valid (CW'(g) < r_count),
            .i_left  ((g == 0) ? HEAD_LINK : w_links[(g == 0) ? 0 : g - 1]),
            .o_link  (w_links[g])
        );
    end

    // landing rank is the number of entries ranked at least as high
    always_comb begin
        w_placed = '0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            w_placed = w_placed + CW'(w_links[i].above);
        end
    end

    assign w_rank_ok = RW'(i_in.read_rank) < RW'(r_count);
    assign w_rd_idx  = IW'(i_in.read_rank);

    always_comb begin
        n_count       = r_count;
        n_accepted    = 1'b0;
        n_placed_rank = '0;
        n_read_valid  = 1'b0;
        n_read_tag    = '0;
        n_read_key    = '0;
        unique case (i_in.operation)
            OP_INSERT: begin
                if (w_ins_ok) begin
                    n_accepted    = 1'b1;
                    n_placed_rank = RANK_W'(w_placed);
                    if (!w_full) begin
                        n_count = r_count + CW'(1);
                    end
                end
            end
            OP_CLEAR: begin
                n_count = '0;
            end
            OP_READ: begin
                if (w_rank_ok) begin
                    n_read_valid = 1'b1;
                    n_read_tag   = w_links[w_rd_idx].tag;
                    n_read_key   = w_links[w_rd_idx].key;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_entry_count <= COUNT_W'(n_count);
            r_accepted    <= n_accepted;
            r_placed_rank <= n_placed_rank;
            r_read_valid  <= n_read_valid;
            r_read_tag    <= n_read_tag;
            r_read_key    <= n_read_key;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.entry_count = r_entry_count;
    assign o_out.accepted    = r_accepted;
    assign o_out.placed_rank = r_placed_rank;
    assign o_out.read_valid  = r_read_valid;
    assign o_out.read_tag    = r_read_tag;
    assign o_out.read_key    = r_read_key;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(TABLE_DEPTH))
        else $error("entry count above table depth");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_in.operation == OP_CLEAR) |=> (r_count == '0))
        else $error("clear did not empty the table");

    a_write_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.wr_en |=> (r_count != '0))
        else $error("table empty after an accepted insert");

    a_one_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.read_valid) |-> !o_out.accepted)
        else $error("result word flags both insert and read");

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out.ready) |=> (r_out_valid && $stable(r_count)))
        else $error("table changed while a result word was stalled");

endmodule

`default_nettype wire

// ===== sim/top_k_max_tracker_unit_tb.sv =====
// top_k_max_tracker_unit_tb: self-checking bench for the top-k max tracker
// depends on tkmt_pkg, tkmt_if and top_k_max_tracker_unit
// directed ranking cases, then random insert/read/clear traffic with random stalls

module top_k_max_tracker_unit_tb;
    import tkmt_pkg::*;

    localparam int DEPTH          = 5;
    localparam int RANDOM_WORDS   = 700;
    localparam int HOLD_CYCLES    = 120;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 8;

    // code 3 has no enum member in the package
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [COUNT_W-1:0] entry_count;
        logic               accepted;
        logic [RANK_W-1:0]  placed_rank;
        logic               read_valid;
        logic [TAG_W-1:0]   read_tag;
        logic [KEY_W-1:0]   read_key;
    } t_outcome;

    class rank_scoreboard;
        logic [TAG_W-1:0] slot_tag [DEPTH];
        logic [KEY_W-1:0] slot_key [DEPTH];
        int unsigned      held;
        t_outcome         outcomes_due [$];
        int               errors;
        int               checked;
        int               words_in;
        int               inserts_taken;
        int               displacements;
        int               read_hits;

        function new();
            held          = 0;
            errors        = 0;
            checked       = 0;
            words_in      = 0;
            inserts_taken = 0;
            displacements = 0;
            read_hits     = 0;
        endfunction

        // table must have room; returns the landing rank
        function int unsigned place_sorted(logic [TAG_W-1:0] tag, logic [KEY_W-1:0] key);
            int unsigned pos;
            int unsigned i;
            pos = 0;
            while (pos < held && slot_key[pos] >= key)
                pos++;
            for (i = held; i > pos; i--) begin
                slot_tag[i] = slot_tag[i-1];
                slot_key[i] = slot_key[i-1];
            end
            slot_tag[pos] = tag;
            slot_key[pos] = key;
            held++;
            return pos;
        endfunction

        function void predict_outcome(logic [OP_W-1:0] op, logic [TAG_W-1:0] tag,
                                      logic [KEY_W-1:0] key, logic [RANK_W-1:0] rank);
            t_outcome    r;
            int unsigned m;
            int unsigned i;
            r = '0;
            words_in++;
            if (op == OP_INSERT) begin
                if (held < DEPTH) begin
                    r.placed_rank = RANK_W'(place_sorted(tag, key));
                    r.accepted    = 1'b1;
                    inserts_taken++;
                end else if (key > slot_key[DEPTH-1]) begin
                    // drop the first entry tied at the minimum, close the gap
                    m = 0;
                    while (slot_key[m] != slot_key[DEPTH-1])
                        m++;
                    for (i = m; i + 1 < held; i++) begin
                        slot_tag[i] = slot_tag[i+1];
                        slot_key[i] = slot_key[i+1];
                    end
                    held--;
                    r.placed_rank = RANK_W'(place_sorted(tag, key));
                    r.accepted    = 1'b1;
                    inserts_taken++;
                    displacements++;
                end
            end else if (op == OP_CLEAR) begin
                held = 0;
            end else if (op == OP_READ) begin
                if (rank < held) begin
                    r.read_valid = 1'b1;
                    r.read_tag   = slot_tag[rank];
                    r.read_key   = slot_key[rank];
                    read_hits++;
                end
            end
            r.entry_count = COUNT_W'(held);
            outcomes_due.push_back(r);
        endfunction

        task report(string what);
            $display("ERROR: %s", what);
            errors++;
        endtask

        task compare_field(string name, int unsigned got, int unsigned want);
            if (got != want)
                report($sformatf("result %0d: %s is 0x%0h, expected 0x%0h",
                                 checked, name, got, want));
        endtask

        task check_outcome(t_outcome got);
            t_outcome want;
            if (outcomes_due.size() == 0) begin
                report($sformatf("result %0d arrived with nothing outstanding", checked));
            end else begin
                want = outcomes_due.pop_front();
                compare_field("entry_count", got.entry_count, want.entry_count);
                compare_field("accepted",    got.accepted,    want.accepted);
                compare_field("placed_rank", got.placed_rank, want.placed_rank);
                compare_field("read_valid",  got.read_valid,  want.read_valid);
                compare_field("read_tag",    got.read_tag,    want.read_tag);
                compare_field("read_key",    got.read_key,    want.read_key);
            end
            checked++;
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;
    bit   steady;

    tkmt_in_if  u_in_ch ();
    tkmt_out_if u_out_ch ();

    rank_scoreboard ranks = new();

    top_k_max_tracker_unit #(
        .TABLE_DEPTH (DEPTH)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (u_in_ch),
        .o_out   (u_out_ch)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // mostly short gaps, a few long ones, none during the steady stretch
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 45);
    endfunction

    task automatic send_word(input logic [OP_W-1:0] op, input logic [TAG_W-1:0] tag,
                             input logic [KEY_W-1:0] key, input logic [RANK_W-1:0] rank);
        int gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            u_in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        u_in_ch.valid     <= 1'b1;
        u_in_ch.operation <= op;
        u_in_ch.item_tag  <= tag;
        u_in_ch.item_key  <= key;
        u_in_ch.read_rank <= rank;
        do @(posedge i_clk); while (!u_in_ch.ready);
        ranks.predict_outcome(op, tag, key, rank);
    endtask

    task automatic send_random_words();
        int               n;
        int               r;
        int               key_mode;
        logic [KEY_W-1:0] ramp;
        logic [KEY_W-1:0] key;
        logic [RANK_W-1:0] rank;
        logic [OP_W-1:0]  op;
        key_mode = 0;
        ramp     = '0;
        for (n = 0; n < RANDOM_WORDS; n++) begin
            steady = (n >= 300 && n < 400);
            case (key_mode)
                0: key = KEY_W'($urandom());
                1: key = KEY_W'($urandom_range(0, 7));          // heavy ties
                2: key = KEY_W'($urandom_range(16'hFFF8, 16'hFFFF));
                default: begin
                    // rising keys keep displacing the minimum
                    ramp = ramp + KEY_W'($urandom_range(0, 3));
                    key  = ramp;
                end
            endcase
            if ($urandom_range(0, 9) < 8)
                rank = RANK_W'($urandom_range(0, DEPTH - 1));
            else
                rank = RANK_W'($urandom_range(0, 7));
            r = $urandom_range(0, 99);
            if (r < 62) begin
                op = OP_INSERT;
            end else if (r < 89) begin
                op = OP_READ;
            end else if (r < 95) begin
                op       = OP_CLEAR;
                key_mode = $urandom_range(0, 3);
                ramp     = KEY_W'($urandom());
            end else begin
                op = OP_UNUSED;
            end
            send_word(op, TAG_W'($urandom()), key, rank);
        end
        steady = 1'b0;
    endtask

    // result side: random stalls plus one long hold so the block backs up
    initial begin
        int  stall_left;
        bit  hold_done;
        stall_left = 0;
        hold_done  = 1'b0;
        u_out_ch.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (!hold_done && ranks.checked >= 200) begin
                hold_done = 1'b1;
                u_out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            if (stall_left > 0) begin
                u_out_ch.ready <= 1'b0;
                stall_left--;
            end else begin
                u_out_ch.ready <= 1'b1;
                stall_left = pick_gap();
            end
            @(posedge i_clk);
            if (u_out_ch.valid && u_out_ch.ready)
                ranks.check_outcome('{u_out_ch.entry_count, u_out_ch.accepted,
                                      u_out_ch.placed_rank, u_out_ch.read_valid,
                                      u_out_ch.read_tag, u_out_ch.read_key});
        end
    end

    // ends the run if no word moves on either side for too long
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((u_in_ch.valid && u_in_ch.ready) || (u_out_ch.valid && u_out_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: %0d cycles without progress", WATCHDOG_LIMIT);
        $display("Some tests failed");
        $finish;
    end

    initial begin
        int r;
        steady             = 1'b0;
        i_rst_n           <= 1'b0;
        u_in_ch.valid     <= 1'b0;
        u_in_ch.operation <= OP_INSERT;
        u_in_ch.item_tag  <= '0;
        u_in_ch.item_key  <= '0;
        u_in_ch.read_rank <= '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_word(OP_READ,   16'h0000, 16'h0000, 3'd0);    // read on empty table
        send_word(OP_INSERT, 16'hFFFF, 16'h1000, 3'd0);
        send_word(OP_INSERT, 16'h0000, 16'h1000, 3'd7);    // tie lands after older entry
        send_word(OP_INSERT, 16'h0001, 16'hFFFF, 3'd0);
        send_word(OP_INSERT, 16'h0002, 16'h0000, 3'd0);
        send_word(OP_INSERT, 16'h0003, 16'h0000, 3'd0);    // table now full
        send_word(OP_INSERT, 16'h0004, 16'h0000, 3'd0);    // equal to minimum, rejected
        send_word(OP_INSERT, 16'h0005, 16'h0001, 3'd0);    // displaces first tied minimum
        send_word(OP_INSERT, 16'h0006, 16'h0001, 3'd0);
        send_word(OP_INSERT, 16'h0007, 16'h0001, 3'd0);    // rejected
        for (r = 0; r < 8; r += 2)
            send_word(OP_READ, 16'hFFFF, 16'hFFFF, RANK_W'(r));
        send_word(OP_UNUSED, 16'hFFFF, 16'hFFFF, 3'd7);
        send_word(OP_CLEAR,  16'hFFFF, 16'hFFFF, 3'd7);
        send_word(OP_READ,   16'h0000, 16'h0000, 3'd0);    // read after clear
        for (r = 0; r < DEPTH; r++)
            send_word(OP_INSERT, TAG_W'(r), 16'h0007, 3'd0);
        send_word(OP_INSERT, 16'hBEEF, 16'h0008, 3'd0);    // all tied, rank 0 goes
        send_word(OP_READ,   16'h0000, 16'h0000, 3'd1);

        send_random_words();

        @(negedge i_clk);
        u_in_ch.valid <= 1'b0;
        while (ranks.outcomes_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (ranks.outcomes_due.size() != 0)
            ranks.report($sformatf("%0d results never arrived", ranks.outcomes_due.size()));

        $display("run: %0d words sent, %0d results checked", ranks.words_in, ranks.checked);
        $display("run: %0d inserts taken, %0d displaced a minimum, %0d reads hit an entry",
                 ranks.inserts_taken, ranks.displacements, ranks.read_hits);
        if (ranks.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== top_k_max_tracker_unit.f =====
src/tkmt_pkg.sv
src/tkmt_if.sv
src/tkmt_cell.sv
src/top_k_max_tracker_unit.sv
sim/top_k_max_tracker_unit_tb.sv
